[rtl/assert_macros.svh]
// Assertion shorthands shared by the RTL; clk and rst come from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every cycle out of reset.
`define ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cidot_pkg.sv]
`timescale 1ns / 1ps
package cidot_pkg;

  // Table is spread over a fixed row of cells; slot = {row, cell}.
  localparam int CELLS  = 8;
  localparam int CELL_W = 3;

  localparam int READ_IDX_W = 9;
  localparam int SLOT_W     = 9;
  localparam int DISTINCT_W = 10;
  localparam int PLAIN_W    = 29;

  localparam int EXT_FLAG_BIT = 2;
  localparam int EXT_SHIFT    = 3;
  localparam int STD_SHIFT    = 21;

  localparam logic [31:0] REPORT_MIN_RESET = 32'd2;
  localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;

  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef enum logic [1:0] {
    MODE_SCAN  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } beat_mode_t;

  // Beat handed from cell to cell. For a scan, word holds the key; once a cell
  // matches, found/lane/count describe the hit. For a read, lane is the target.
  typedef struct packed {
    logic              valid;
    logic              last;
    beat_mode_t        mode;
    logic [CELL_W-1:0] lane;
    logic              found;
    logic [31:0]       word;
    logic [31:0]       count;
  } cell_beat_t;

  typedef struct packed {
    logic                  opcode;
    logic [31:0]           frame_id;
    logic [READ_IDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic [31:0]           occurrences;
    logic                  newly_added;
    logic                  zero_ignored;
    logic                  table_full;
    logic [DISTINCT_W-1:0] distinct_ids;
    logic [31:0]           stored_word;
    logic                  is_extended;
    logic [PLAIN_W-1:0]    plain_id;
    logic                  entry_valid;
    logic                  reportable;
  } result_t;

endpackage

[rtl/cidot_cell.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cidot_cell #(
  parameter int ROWS = 64,
  parameter int FILL_W = 10,
  parameter int CELL_IDX = 0,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [FILL_W-1:0]      fill,
  input  cidot_pkg::cell_beat_t  prev_beat,
  input  logic [ROW_W-1:0]       prev_row,
  input  logic [ROW_W-1:0]       prev_frow,
  output cidot_pkg::cell_beat_t  beat,
  output logic [ROW_W-1:0]       row,
  output logic [ROW_W-1:0]       frow
);

  localparam int AW = ROW_W + cidot_pkg::CELL_W;
  localparam int CW = (AW > FILL_W) ? AW : FILL_W;
  localparam logic [cidot_pkg::CELL_W-1:0] MY_CELL = cidot_pkg::CELL_W'(CELL_IDX);

  // bank: {id word, count} per row
  logic [63:0] mem [ROWS];
  logic [63:0] rd;

  cidot_pkg::cell_beat_t a_beat;
  logic [ROW_W-1:0]      a_row;
  logic [ROW_W-1:0]      a_frow;

  cidot_pkg::cell_beat_t beat_next;
  logic [ROW_W-1:0]      frow_next;

  logic          wr_en;
  logic [AW-1:0] slot_a;
  logic          in_use;
  logic          id_hit;
  logic          rd_hit;
  logic          found_live;

  assign wr_en = prev_beat.valid && (prev_beat.mode == cidot_pkg::MODE_WRITE) &&
                 (prev_beat.lane == MY_CELL);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[prev_row] <= {prev_beat.word, prev_beat.count};
    end
    rd <= mem[prev_row];
  end

  // stage a: beat waits alongside the bank read
  always_ff @(posedge clk) begin
    if (rst) begin
      a_beat <= '0;
    end else begin
      a_beat <= prev_beat;
    end
    a_row  <= prev_row;
    a_frow <= prev_frow;
  end

  assign slot_a = {a_row, MY_CELL};
  assign in_use = CW'(slot_a) < CW'(fill);
  assign id_hit = a_beat.valid && (a_beat.mode == cidot_pkg::MODE_SCAN) && !a_beat.found &&
                  in_use && (rd[63:32] == a_beat.word);
  assign rd_hit = a_beat.valid && (a_beat.mode == cidot_pkg::MODE_READ) &&
                  (a_beat.lane == MY_CELL);
  assign found_live = a_beat.valid && (a_beat.mode == cidot_pkg::MODE_SCAN) &&
                      a_beat.found && in_use;

  always_comb begin
    beat_next = a_beat;
    frow_next = a_frow;
    if (id_hit || rd_hit) begin
      beat_next.found = 1'b1;
      beat_next.lane  = MY_CELL;
      beat_next.word  = rd[63:32];
      beat_next.count = rd[31:0];
      frow_next       = a_row;
    end
  end

  // stage b: hand to neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= '0;
    end else begin
      beat <= beat_next;
    end
    row  <= a_row;
    frow <= frow_next;
  end

  `ASSERT_IMPLY(a_distinct_ids, found_live, rd[63:32] != a_beat.word, "id held in two slots")
  `ASSERT_IMPLY(a_row_range, prev_beat.valid, prev_row <= ROW_W'(ROWS - 1), "row beyond bank depth")
  `ASSERT_NEXT(a_beat_passes, a_beat.valid, beat.valid, "beat dropped in cell")

endmodule

[rtl/can_id_occurrence_table.sv]
`timescale 1ns / 1ps
// Observe: the scan issues ROWS = ceil(TABLE_DEPTH / 8) rows (64 at 512), one row per cycle
//   into an 8-cell chain, 2 registers per cell; the result is then loaded in the finish step.
// Read: one beat through the head, 16 chain stages and finish. Zero identifier or unused slot: straight to finish.
// One item at a time: next item beat is taken the cycle after the result is loaded.
// Sync reset clears fill count, control and result valid, report_min_count back to 2;
// the id/count banks are not cleared, the fill count marks which slots are live.
`include "assert_macros.svh"
module can_id_occurrence_table #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  cidot_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output cidot_pkg::result_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  localparam int CELLS  = cidot_pkg::CELLS;
  localparam int CELL_W = cidot_pkg::CELL_W;
  localparam int ROWS   = (TABLE_DEPTH + CELLS - 1) / CELLS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW     = ROW_W + CELL_W;
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int IW     = (FILL_W > cidot_pkg::READ_IDX_W) ? FILL_W : cidot_pkg::READ_IDX_W;

  localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(TABLE_DEPTH);
  localparam logic [AW-1:0]     LAST_SLOT  = AW'(TABLE_DEPTH - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_WAIT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  // latched item
  logic                             op_q;
  logic [31:0]                      key_q;
  logic [cidot_pkg::READ_IDX_W-1:0] ridx_q;
  logic                             read_ok;
  logic                             read_ok_now;
  logic [AW-1:0]                    ridx_slot;

  logic [ROW_W-1:0] scan_row, scan_row_next;
  logic [FILL_W-1:0] fill, fill_fin;
  logic [31:0] min_count;

  // chain head and links
  cidot_pkg::cell_beat_t head, head_next;
  logic [ROW_W-1:0]      head_row, head_row_next;
  cidot_pkg::cell_beat_t link_beat [CELLS+1];
  logic [ROW_W-1:0]      link_row  [CELLS+1];
  logic [ROW_W-1:0]      link_frow [CELLS+1];
  cidot_pkg::cell_beat_t tail;
  logic                  tail_live;
  logic                  tail_done;
  logic                  searching;

  // hit collected from the chain tail
  logic              hit;
  logic [ROW_W-1:0]  hit_row;
  logic [CELL_W-1:0] hit_cell;
  logic [31:0]       hit_word;
  logic [31:0]       hit_count;

  // finish-step results
  cidot_pkg::result_t    fin;
  cidot_pkg::cell_beat_t wr_beat;
  logic [ROW_W-1:0]      wr_row;
  logic                  ent_on;
  logic [AW-1:0]         ent_slot;
  logic [31:0]           ent_word;
  logic [31:0]           ent_count;
  logic                  ext;
  logic                  load_result;
  logic                  accept;
  logic                  out_free;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign cfg_ready  = 1'b1;

  assign read_ok_now = IW'(item.read_index) < IW'(fill);
  assign ridx_slot   = AW'(item.read_index);

  // cell row: each beat passes both registers of a cell before it reaches the next cell
  assign link_beat[0] = head;
  assign link_row[0]  = head_row;
  assign link_frow[0] = '0;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    cidot_cell #(
      .ROWS(ROWS),
      .FILL_W(FILL_W),
      .CELL_IDX(g)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .fill(fill),
      .prev_beat(link_beat[g]),
      .prev_row(link_row[g]),
      .prev_frow(link_frow[g]),
      .beat(link_beat[g+1]),
      .row(link_row[g+1]),
      .frow(link_frow[g+1])
    );
  end

  assign tail      = link_beat[CELLS];
  assign tail_live = tail.valid && (tail.mode != cidot_pkg::MODE_WRITE);
  assign tail_done = tail_live && tail.last;
  assign searching = (state == S_SCAN) || (state == S_WAIT);

  // Finish step: build the result and, for an observed identifier, the write-back beat.
  always_comb begin
    fin       = '0;
    wr_beat   = '0;
    wr_row    = '0;
    fill_fin  = fill;
    ent_on    = 1'b0;
    ent_slot  = '0;
    ent_word  = '0;
    ent_count = '0;
    ext       = 1'b0;
    priority if (op_q == cidot_pkg::OP_OBSERVE && key_q == '0) begin
      fin.zero_ignored = 1'b1;
    end else if (op_q == cidot_pkg::OP_READ) begin
      fin.slot = ridx_q;
      if (read_ok) begin
        ent_on    = 1'b1;
        ent_slot  = {hit_row, hit_cell};
        ent_word  = hit_word;
        ent_count = hit_count;
      end
    end else begin
      ent_on   = 1'b1;
      ent_word = key_q;
      if (hit) begin
        ent_slot  = {hit_row, hit_cell};
        ent_count = (hit_count == cidot_pkg::COUNT_MAX) ? hit_count : hit_count + 32'd1;
      end else begin
        // new identifier: append, or replace the last slot when full
        fin.newly_added = 1'b1;
        ent_count       = 32'd1;
        if (fill < DEPTH_FILL) begin
          ent_slot = AW'(fill);
          fill_fin = fill + FILL_W'(1);
        end else begin
          ent_slot = LAST_SLOT;
        end
      end
      wr_beat.valid = 1'b1;
      wr_beat.mode  = cidot_pkg::MODE_WRITE;
      wr_beat.lane  = ent_slot[CELL_W-1:0];
      wr_beat.word  = key_q;
      wr_beat.count = ent_count;
      wr_row        = ent_slot[AW-1:CELL_W];
    end
    if (ent_on) begin
      ext             = ent_word[cidot_pkg::EXT_FLAG_BIT];
      fin.slot        = cidot_pkg::SLOT_W'(ent_slot);
      fin.occurrences = ent_count;
      fin.stored_word = ent_word;
      fin.is_extended = ext;
      fin.plain_id    = ext ? cidot_pkg::PLAIN_W'(ent_word >> cidot_pkg::EXT_SHIFT)
                            : cidot_pkg::PLAIN_W'(ent_word >> cidot_pkg::STD_SHIFT);
      fin.entry_valid = 1'b1;
      fin.reportable  = ent_count >= min_count;
    end
    fin.table_full   = (fill_fin == DEPTH_FILL);
    fin.distinct_ids = cidot_pkg::DISTINCT_W'(fill_fin);
  end

  // Sequencer: scan issues one row per cycle; read issues one beat; finish issues the write-back beat.
  always_comb begin
    state_next    = state;
    head_next     = '0;
    head_row_next = '0;
    scan_row_next = scan_row;
    load_result   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (item.opcode == cidot_pkg::OP_OBSERVE && item.frame_id != '0) begin
            scan_row_next = '0;
            state_next    = S_SCAN;
          end else if (item.opcode == cidot_pkg::OP_READ && read_ok_now) begin
            head_next.valid = 1'b1;
            head_next.last  = 1'b1;
            head_next.mode  = cidot_pkg::MODE_READ;
            head_next.lane  = ridx_slot[CELL_W-1:0];
            head_row_next   = ridx_slot[AW-1:CELL_W];
            state_next      = S_WAIT;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        head_next.valid = 1'b1;
        head_next.last  = (scan_row == LAST_ROW);
        head_next.mode  = cidot_pkg::MODE_SCAN;
        head_next.word  = key_q;
        head_row_next   = scan_row;
        scan_row_next   = scan_row + ROW_W'(1);
        if (scan_row == LAST_ROW) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (tail_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          load_result   = 1'b1;
          head_next     = wr_beat;
          head_row_next = wr_row;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    head_row <= head_row_next;
    scan_row <= scan_row_next;
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      fill         <= '0;
      min_count    <= cidot_pkg::REPORT_MIN_RESET;
      result_valid <= 1'b0;
      hit          <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      if (load_result) begin
        fill <= fill_fin;
      end
      if (cfg_valid && cfg_ready) begin
        min_count <= cfg_data;
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        hit <= 1'b0;
      end else if (tail_live && tail.found) begin
        hit <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= item.opcode;
      key_q   <= item.frame_id;
      ridx_q  <= item.read_index;
      read_ok <= read_ok_now;
    end
    if (tail_live && tail.found) begin
      hit_row   <= link_frow[CELLS];
      hit_cell  <= tail.lane;
      hit_word  <= tail.word;
      hit_count <= tail.count;
    end
    if (load_result) begin
      result <= fin;
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, fill <= DEPTH_FILL, "fill count beyond table depth")
  `ASSERT_NEXT(a_fill_on_finish, state != S_FINISH, $stable(fill), "fill moved outside finish")
  `ASSERT_IMPLY(a_tail_in_search, tail_live, searching, "search beat seen while idle")
  `ASSERT_IMPLY(a_single_hit, tail_live && tail.found, !hit, "second hit for one item")

endmodule

[test/tb_can_id_occurrence_table.sv]
`timescale 1ns / 1ps
module tb_can_id_occurrence_table;

  localparam int TABLE_DEPTH = 512;
  // Longest single item: 64 rows issued plus the chain and finish, with margin.
  localparam int SETTLE_CYCLES = 120;
  // Generous ceiling on the whole run, at a 4 ns clock.
  localparam int RUN_LIMIT_NS = 3_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  cidot_pkg::item_t   item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  cidot_pkg::result_t result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [31:0]        cfg_data = '0;

  can_id_occurrence_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the occurrence table. Updated when an item beat is accepted,
  // so it always reflects every item the block has taken so far.
  // ---------------------------------------------------------------------------
  logic [31:0] known_ids   [TABLE_DEPTH];
  logic [31:0] seen_counts [TABLE_DEPTH];
  int          live_slots = 0;
  logic [31:0] report_floor = cidot_pkg::REPORT_MIN_RESET;

  cidot_pkg::result_t expected_results[$];

  int mismatch_count  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int cfg_writes      = 0;
  int overwrites_seen = 0;
  int burst_left      = 0;

  // Receiver-side hold-off, requested by a test, counted in its own process.
  int   hold_request = 0;
  int   hold_cycles;
  logic holding = 1'b0;
  logic [7:0] stall_phase = '0;

  // Fill in the entry-describing fields of a result for one table slot.
  function automatic cidot_pkg::result_t describe_slot(cidot_pkg::result_t r, int s);
    logic [31:0] w;
    w               = known_ids[s];
    r.slot          = cidot_pkg::SLOT_W'(s);
    r.occurrences   = seen_counts[s];
    r.stored_word   = w;
    r.is_extended   = w[cidot_pkg::EXT_FLAG_BIT];
    r.plain_id      = w[cidot_pkg::EXT_FLAG_BIT]
                      ? cidot_pkg::PLAIN_W'(w >> cidot_pkg::EXT_SHIFT)
                      : cidot_pkg::PLAIN_W'(w >> cidot_pkg::STD_SHIFT);
    r.entry_valid   = 1'b1;
    r.reportable    = (seen_counts[s] >= report_floor);
    return r;
  endfunction

  // Apply one item to the shadow table and return the result it must produce.
  function automatic cidot_pkg::result_t predict_outcome(cidot_pkg::item_t beat);
    cidot_pkg::result_t r;
    int      hit;
    int      tgt;
    int      k;
    r   = '0;
    hit = -1;
    if (beat.opcode == cidot_pkg::OP_OBSERVE) begin
      if (beat.frame_id == '0) begin
        r.zero_ignored = 1'b1;
      end else begin
        for (k = 0; k < live_slots; k++) begin
          if (known_ids[k] == beat.frame_id) begin
            hit = k;
            break;
          end
        end
        if (hit >= 0) begin
          tgt = hit;
          if (seen_counts[tgt] != cidot_pkg::COUNT_MAX) seen_counts[tgt] = seen_counts[tgt] + 1;
        end else begin
          if (live_slots < TABLE_DEPTH) begin
            tgt = live_slots;
            live_slots++;
          end else begin
            // full table: a miss replaces the last slot
            tgt = TABLE_DEPTH - 1;
            overwrites_seen++;
          end
          known_ids[tgt]   = beat.frame_id;
          seen_counts[tgt] = 32'd1;
        end
        r = describe_slot(r, tgt);
        r.newly_added = (hit < 0);
      end
    end else if (int'(beat.read_index) < live_slots) begin
      r = describe_slot(r, int'(beat.read_index));
    end else begin
      r.slot = beat.read_index;
    end
    r.table_full   = (live_slots >= TABLE_DEPTH);
    r.distinct_ids = cidot_pkg::DISTINCT_W'(live_slots);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH result %0d %s: got %h want %h", results_checked, what, got, want);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_mismatch(name, got, want);
  endtask

  task automatic compare_result(input cidot_pkg::result_t got, input cidot_pkg::result_t want);
    check_field("slot",         got.slot,         want.slot);
    check_field("occurrences",  got.occurrences,  want.occurrences);
    check_field("newly_added",  got.newly_added,  want.newly_added);
    check_field("zero_ignored", got.zero_ignored, want.zero_ignored);
    check_field("table_full",   got.table_full,   want.table_full);
    check_field("distinct_ids", got.distinct_ids, want.distinct_ids);
    check_field("stored_word",  got.stored_word,  want.stored_word);
    check_field("is_extended",  got.is_extended,  want.is_extended);
    check_field("plain_id",     got.plain_id,     want.plain_id);
    check_field("entry_valid",  got.entry_valid,  want.entry_valid);
    check_field("reportable",   got.reportable,   want.reportable);
  endtask

  // Result side: check every accepted beat, then pick the next ready value.
  // Ready follows its own pattern, switching style as the top two bits of stall_phase change.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_ready) begin
      if (expected_results.size() == 0) flag_mismatch("unexpected beat", '0, '0);
      else compare_result(result, expected_results.pop_front());
      results_checked++;
    end
    stall_phase <= stall_phase + 8'd1;
    if (holding) begin
      result_ready <= 1'b0;
    end else begin
      case (stall_phase[7:6])
        2'd0: result_ready <= 1'b1;
        2'd1: result_ready <= ($urandom_range(0, 1) == 0);
        2'd2: result_ready <= ($urandom_range(0, 3) == 0);
        default: result_ready <= stall_phase[2];
      endcase
    end
  end

  // Long hold-off of result_ready on request, counted in cycles.
  initial forever begin
    wait (hold_request != 0);
    hold_cycles  = hold_request;
    hold_request = 0;
    @(posedge clk);
    holding <= 1'b1;
    repeat (hold_cycles) @(posedge clk);
    holding <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Item side
  // ---------------------------------------------------------------------------
  // Send one beat. Items go out in bursts; between bursts valid may drop for a
  // random gap. Valid stays high across back-to-back beats in a burst.
  task automatic send_item(input cidot_pkg::item_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 10);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item       <= beat;
    do @(posedge clk); while (item_ready !== 1'b1);
    expected_results.push_back(predict_outcome(beat));
    items_sent++;
  endtask

  task automatic observe(input logic [31:0] id);
    cidot_pkg::item_t b;
    b.opcode     = cidot_pkg::OP_OBSERVE;
    b.frame_id   = id;
    b.read_index = cidot_pkg::READ_IDX_W'($urandom);
    send_item(b);
  endtask

  task automatic read_slot(input int idx);
    cidot_pkg::item_t b;
    b.opcode     = cidot_pkg::OP_READ;
    b.frame_id   = $urandom;
    b.read_index = cidot_pkg::READ_IDX_W'(idx);
    send_item(b);
  endtask

  // Identifier mix: hits on live entries, zero, both register formats, raw words.
  function automatic logic [31:0] pick_frame_id(input int hit_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (live_slots > 0 && roll < hit_pct)
      return known_ids[$urandom_range(0, live_slots - 1)];
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll < 5)  return {11'($urandom_range(0, 2047)), 21'($urandom) & 21'h1FFFFB};
    if (roll < 9)  return {29'($urandom), 3'b100};
    return $urandom;
  endfunction

  task automatic send_random(input int hit_pct, input int read_pct);
    if ($urandom_range(0, 99) < read_pct) begin
      if (live_slots > 0 && $urandom_range(0, 9) < 7) read_slot($urandom_range(0, live_slots - 1));
      else read_slot($urandom_range(0, 511));
    end else begin
      observe(pick_frame_id(hit_pct));
    end
  endtask

  // Stop offering, let every expected beat arrive, then let the block settle.
  task automatic drain();
    item_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // report_min_count is only written with the block idle.
  task automatic write_report_floor(input logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    report_floor = v;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty-table reads, zero id, format extremes, hits and the reset threshold.
  task automatic test_directed();
    int k;
    read_slot(0);
    read_slot(511);
    observe(32'h0000_0000);
    observe(32'hFFFF_FFFF);
    observe(32'h0000_0004);
    observe(32'hFFE0_0000);
    observe(32'h0020_0000);
    observe(32'h0000_0001);
    observe(32'h8000_0000);
    observe(32'hFFFF_FFFF);
    observe(32'hFFFF_FFFF);
    observe(32'hFFE0_0000);
    observe(32'h0000_0000);
    observe(32'h7FFF_FFFB);
    for (k = 0; k < live_slots; k++) read_slot(k);
    read_slot(live_slots);
    read_slot(300);
  endtask

  // Threshold sweep: top and bottom of the range and values near the counts.
  task automatic test_report_floor();
    logic [31:0] floors[5];
    int          f;
    int          k;
    floors = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd3, 32'($urandom_range(2, 6))};
    for (f = 0; f < 5; f++) begin
      write_report_floor(floors[f]);
      for (k = 0; k < live_slots; k++) read_slot(k);
      observe(pick_frame_id(100));
    end
  endtask

  // Mostly repeats of live ids with a mix of reads and new ids.
  task automatic test_random_mix();
    int n;
    write_report_floor($urandom);
    for (n = 0; n < 200; n++) send_random(60, 30);
    write_report_floor(32'($urandom_range(1, 4)));
    for (n = 0; n < 200; n++) send_random(60, 30);
  endtask

  // Results held off for a long stretch while items keep coming.
  task automatic test_backpressure();
    int n;
    drain();
    hold_request = 400;
    burst_left   = 30;
    for (n = 0; n < 12; n++) send_random(50, 30);
  endtask

  // Grow the table to its full depth, mostly with new identifiers.
  task automatic test_fill_to_full();
    while (live_slots < TABLE_DEPTH) send_random(10, 10);
  endtask

  // Full table: misses overwrite the last slot, which must then be hittable.
  task automatic test_full_table();
    logic [31:0] fresh;
    int          n;
    write_report_floor(32'($urandom_range(1, 3)));
    read_slot(TABLE_DEPTH - 1);
    read_slot(TABLE_DEPTH - 2);
    fresh = {$urandom} | 32'h1;
    observe(fresh);
    observe(fresh);
    read_slot(TABLE_DEPTH - 1);
    observe(known_ids[0]);
    observe(32'h0000_0000);
    for (n = 0; n < 150; n++) send_random(40, 30);
    read_slot(511);
    write_report_floor(cidot_pkg::REPORT_MIN_RESET);
    for (n = 0; n < 20; n++) send_random(40, 40);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_report_floor();
    test_random_mix();
    test_backpressure();
    test_fill_to_full();
    test_full_table();
    drain();

    $display("run: %0d items, %0d results checked, %0d threshold writes", items_sent,
             results_checked, cfg_writes);
    $display("run: table reached %0d entries, %0d last-slot overwrites, %0d mismatches",
             live_slots, overwrites_seen, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("tb: failure");
    $finish;
  end

endmodule

[can_id_occurrence_table.f]
+incdir+rtl
rtl/cidot_pkg.sv
rtl/cidot_cell.sv
rtl/can_id_occurrence_table.sv
test/tb_can_id_occurrence_table.sv
